// ===== rtl/clfbw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfbw_pkg
// Shared types, constants and lookup functions for the four-bit character
// LCD writer.
// ----------------------------------------------------------------------------
package clfbw_pkg;

	typedef enum logic [2:0] {
		OP_INIT       = 3'd0,
		OP_COMMAND    = 3'd1,
		OP_CHAR       = 3'd2,
		OP_GOTO       = 3'd3,
		OP_CLEAR      = 3'd4,
		OP_HOME       = 3'd5,
		OP_GLYPH_SEL  = 3'd6,
		OP_GLYPH_ROW  = 3'd7
	} op_t;

	localparam int unsigned CURSOR_WRAP_DEF = 32;
	localparam int unsigned STEP_W          = 5;
	localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd16;

	localparam logic [7:0] NIBBLE_WAIT_RST = 8'd2;
	localparam logic [7:0] INIT_WAIT_MS    = 8'd15;
	localparam logic [7:0] CLEAR_EXTRA_MS  = 8'd5;

	localparam logic [7:0] CMD_DDRAM_ADDR = 8'h80;
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_HOME       = 8'h02;
	localparam logic [7:0] CMD_CGRAM_ADDR = 8'h40;

	// Controller to datapath
	typedef struct packed {
		logic              start;
		logic              load;
		logic [STEP_W-1:0] step;
	} clfbw_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last;
	} clfbw_sts_t;

	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0, 3'd1, 3'd2: b = 8'h30;
			3'd3:             b = 8'h02;
			3'd4:             b = 8'h2C;
			3'd5:             b = 8'h0C;
			3'd6:             b = 8'h01;
			3'd7:             b = 8'h06;
			default:          b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] init_extra(input logic [2:0] idx);
		logic [7:0] e;
		case (idx)
			3'd0:                   e = 8'd70;
			3'd1, 3'd2:             e = 8'd0;
			3'd3:                   e = 8'd5;
			3'd4, 3'd5, 3'd6, 3'd7: e = 8'd15;
			default:                e = 8'd0;
		endcase
		return e;
	endfunction

	function automatic logic [7:0] row_offset(input logic [1:0] r);
		logic [7:0] o;
		case (r)
			2'd0:    o = 8'h00;
			2'd1:    o = 8'h40;
			2'd2:    o = 8'h14;
			2'd3:    o = 8'h54;
			default: o = 8'h00;
		endcase
		return o;
	endfunction

endpackage

// ===== rtl/clfbw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfbw_ctrl
// Sequencer: accepts a request, steps through its strobes, manages the
// output register handshake.
// ----------------------------------------------------------------------------
module clfbw_ctrl
	import clfbw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output clfbw_cmd_t cmd,
	input  clfbw_sts_t sts
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.start = in_valid && (state_q == ST_IDLE);
		cmd.load  = (state_q == ST_RUN) && (!out_valid_q || !out_stall);
		cmd.step  = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// hold the result until taken, refill on the same edge
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (cmd.load) begin
						step_q <= step_q + 1'b1;
						if (sts.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/clfbw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfbw_dp
// Datapath: request registers, cursor tracking, wait register, step decode
// and the output register.
// ----------------------------------------------------------------------------
module clfbw_dp
	import clfbw_pkg::*;
#(
	parameter int unsigned CURSOR_WRAP = CURSOR_WRAP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wait,
	input  clfbw_cmd_t cmd,
	output clfbw_sts_t sts,
	input  logic [2:0] operation,
	input  logic [7:0] value,
	input  logic [5:0] column,
	input  logic [1:0] row,
	input  logic [2:0] glyph_slot,
	output logic       strobe_res,
	output logic       reg_select,
	output logic [3:0] nibble,
	output logic [7:0] wait_ms,
	output logic [4:0] cursor,
	output logic       last
);

	localparam int unsigned CW  = $clog2(CURSOR_WRAP);
	localparam int unsigned CXW = (CW > 5) ? CW : 5;

	logic [7:0]    base_wait_q;
	logic [CW-1:0] cursor_q;
	op_t           op_q;
	logic [7:0]    byte_q;
	logic [7:0]    extra_q;
	logic          rs_q;

	logic [CW:0]   cur_inc;
	logic [CW-1:0] cur_next;
	op_t           op_in;
	logic [7:0]    byte_in;
	logic [7:0]    extra_in;
	logic          rs_in;

	logic              is_init;
	logic              wait_only;
	logic [STEP_W-1:0] init_pos;
	logic              half;
	logic [7:0]        cur_byte;
	logic [7:0]        cur_extra;
	logic [8:0]        wait_sum;
	logic [CXW-1:0]    cursor_ext;

	logic       strobe_q;
	logic       rs_out_q;
	logic [3:0] nibble_q;
	logic [7:0] wait_q;
	logic [4:0] cursor_out_q;
	logic       last_q;

	// decode the request into one byte, its register select and extra delay
	always_comb begin
		op_in    = op_t'(operation);
		byte_in  = value;
		extra_in = 8'd0;
		rs_in    = 1'b0;
		cur_inc  = {1'b0, cursor_q} + 1'b1;
		cur_next = cursor_q;
		case (op_in)
			OP_CHAR: begin
				rs_in    = 1'b1;
				cur_next = (cur_inc >= (CW+1)'(CURSOR_WRAP)) ? '0 : cur_inc[CW-1:0];
			end
			OP_GOTO: begin
				byte_in = CMD_DDRAM_ADDR + row_offset(row) + {2'b00, column};
			end
			OP_CLEAR: begin
				byte_in  = CMD_CLEAR;
				extra_in = CLEAR_EXTRA_MS;
				cur_next = '0;
			end
			OP_HOME: begin
				byte_in  = CMD_HOME;
				cur_next = '0;
			end
			OP_GLYPH_SEL: begin
				byte_in = CMD_CGRAM_ADDR | {2'b00, glyph_slot, 3'b000};
			end
			OP_GLYPH_ROW: begin
				rs_in = 1'b1;
			end
			OP_INIT, OP_COMMAND: begin
				byte_in = value;
			end
			default: begin
				byte_in = value;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_wait_q <= NIBBLE_WAIT_RST;
			cursor_q    <= '0;
		end else begin
			if (cfg_we) begin
				base_wait_q <= cfg_wait;
			end
			if (cmd.start) begin
				cursor_q <= cur_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q    <= op_in;
			byte_q  <= byte_in;
			extra_q <= extra_in;
			rs_q    <= rs_in;
		end
	end

	// per-step decode; init runs a leading wait then eight table bytes
	always_comb begin
		is_init   = (op_q == OP_INIT);
		wait_only = is_init && (cmd.step == '0);
		init_pos  = cmd.step - 1'b1;
		half      = is_init ? init_pos[0] : cmd.step[0];
		cur_byte  = is_init ? init_byte(init_pos[3:1]) : byte_q;
		cur_extra = is_init ? init_extra(init_pos[3:1]) : extra_q;
		wait_sum  = {1'b0, base_wait_q} + {1'b0, (half ? cur_extra : 8'd0)};
		sts.last  = is_init ? (cmd.step == INIT_LAST_STEP) : cmd.step[0];
		cursor_ext = CXW'(cursor_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cursor_out_q <= cursor_ext[4:0];
			last_q       <= sts.last;
			if (wait_only) begin
				strobe_q <= 1'b0;
				rs_out_q <= 1'b0;
				nibble_q <= 4'd0;
				wait_q   <= INIT_WAIT_MS;
			end else begin
				strobe_q <= 1'b1;
				rs_out_q <= is_init ? 1'b0 : rs_q;
				nibble_q <= half ? cur_byte[3:0] : cur_byte[7:4];
				wait_q   <= wait_sum[8] ? 8'hFF : wait_sum[7:0];
			end
		end
	end

	assign strobe_res = strobe_q;
	assign reg_select = rs_out_q;
	assign nibble     = nibble_q;
	assign wait_ms    = wait_q;
	assign cursor     = cursor_out_q;
	assign last       = last_q;

endmodule

// ===== rtl/char_lcd_four_bit_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_four_bit_writer
// Turns LCD requests into runs of four-bit enable strobes, high nibble first,
// each with register select and a wait in milliseconds.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  operation, value, column, row,
//                                           glyph_slot
// out       source     out_valid/out_stall  strobe_res, reg_select, nibble,
//                                           wait_ms, cursor, last
// cfg       sink       cfg_valid/cfg_ready  nibble_wait_ms
//
// A request is taken while idle, then its steps leave one per cycle unless
// the output stalls: 2 steps for byte requests, 17 for init, counted by the
// step counter of the sequencer.
// Output stall freezes the output register and the step counter.
// A new request is taken while the final step of the previous one still
// waits in the output register.
// Reset clears the sequencer, the cursor (to 0) and the base wait (to 2 ms).
// cfg_ready is always high; write the base wait only while idle.
//
module char_lcd_four_bit_writer
	import clfbw_pkg::*;
#(
	parameter int unsigned CURSOR_WRAP = CURSOR_WRAP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] value,
	input  logic [5:0] column,
	input  logic [1:0] row,
	input  logic [2:0] glyph_slot,
	// step channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       strobe_res,
	output logic       reg_select,
	output logic [3:0] nibble,
	output logic [7:0] wait_ms,
	output logic [4:0] cursor,
	output logic       last,
	// base wait register
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] nibble_wait_ms
);

	clfbw_cmd_t cmd;
	clfbw_sts_t sts;
	logic       cfg_we;

	// the register is a plain flop, so accept every write at once
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencer: request acceptance, step count, output valid
	clfbw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: request decode, cursor, wait math, output register
	clfbw_dp #(
		.CURSOR_WRAP (CURSOR_WRAP)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wait   (nibble_wait_ms),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.value      (value),
		.column     (column),
		.row        (row),
		.glyph_slot (glyph_slot),
		.strobe_res (strobe_res),
		.reg_select (reg_select),
		.nibble     (nibble),
		.wait_ms    (wait_ms),
		.cursor     (cursor),
		.last       (last)
	);

endmodule

// ===== rtl/clfbw_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfbw_chk
// Port-level checks for the four-bit LCD writer, bound to the top level.
// ----------------------------------------------------------------------------
module clfbw_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       strobe_res,
	input logic       reg_select,
	input logic [3:0] nibble,
	input logic [4:0] cursor,
	input logic       last
);

	// a stalled step holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(nibble) && $stable(last))
		else $error("stalled step changed");

	// a taken request blocks the next one while its steps are produced
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	// a run does not break up: a taken non-final step is followed at once
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a run");

	// every step of one run reports the same cursor
	a_cursor_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> $stable(cursor))
		else $error("cursor changed inside a run");

	// a wait-only step drives an idle bus and never closes a run
	a_wait_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !strobe_res |-> nibble == 4'd0 && !reg_select && !last)
		else $error("bad wait-only step");

endmodule

bind char_lcd_four_bit_writer clfbw_chk u_clfbw_chk (.*);
